@@ rtl/nics_pkg.sv @@
package nics_pkg;

  localparam int CFG_W     = 13;
  localparam int COORD_W   = 24;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int DIST_W    = 50;
  localparam int IMG_W     = 3;
  localparam int IDX_W     = 15;
  localparam int IN_DATA_W = 72;
  localparam int OUT_DATA_W = 16;

  localparam logic [IMG_W-1:0] LastImage = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;

  // First member sits in the highest bits, so x lands in the lowest bits.
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

endpackage

@@ rtl/nearest_image_chain_select_unit.sv @@
// Nearest image chain selection.
// Slave stream: one beat per image centre, tdata = {z, y, x}, each a signed
// Q16.8 value of 24 bits, eight beats per molecule. Master stream: one beat
// per molecule carrying the chosen global image index (8*molecule+image) in
// tdata and tlast set on the last molecule of a run. The run length is
// written through cfg_we_i/cfg_wdata_i; the user must write it only while
// the block is idle, which the block does not enforce. Throughput is one
// image beat per cycle while no result waits on a stalled receiver. An
// image beat is registered on input; from that register the three squared
// distances, their sum and the compare with the running minimum are done,
// and processing a molecule's eighth beat loads the master output register.
// Reset clears the counters and the reference and sets the run length to one.
// If the receiver stalls while a result waits, image beats that produce no
// result still flow; the input register holds a molecule's last image until
// the output register is free, and the slave tready stays low meanwhile.
module nearest_image_chain_select_unit
  import nics_pkg::*;
#(
  parameter int MAX_MOLECULES = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata fields from bit 0 up: coord_x[23:0], coord_y[23:0], coord_z[23:0]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata fields from bit 0 up: selected_index[14:0], one zero pad bit
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  localparam int CNT_W  = $clog2(MAX_MOLECULES);
  localparam int CMP_W  = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;
  localparam int IDXF_W = CNT_W + IMG_W;
  localparam logic [CMP_W-1:0] MaxCount = CMP_W'(MAX_MOLECULES);

  logic [CFG_W-1:0] count_q;
  logic             in_valid_q;
  point_t           in_q;
  point_t           ref_q, ref_d;
  point_t           chosen_q, chosen_d;
  logic [DIST_W-1:0] best_q, best_d;
  logic [IMG_W-1:0] best_img_q, best_img_d;
  logic [IMG_W-1:0] img_cnt_q;
  logic [CNT_W-1:0] mol_cnt_q;
  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;
  logic             out_last_q;

  logic             has_result, proc;
  logic             first_img, run_last;
  point_t           ref_eff;
  logic [CMP_W-1:0] cfg_ext, count_m1, mol_ext;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic signed [SQ_W-1:0]   sx, sy, sz;
  logic [DIST_W-1:0] sq_sum;
  logic              take;
  logic [IDXF_W-1:0]       idx_full;
  logic [IDXF_W+IDX_W-1:0] idx_wide;

  // Floor of the mean: sum in 25 bits, arithmetic shift by one.
  function automatic coord_t midpoint(coord_t a, coord_t b);
    logic signed [DIFF_W-1:0] s;
    s = DIFF_W'(a) + DIFF_W'(b);
    return s[DIFF_W-1:1];
  endfunction

  assign has_result    = (img_cnt_q == LastImage);
  assign proc          = in_valid_q && (!has_result || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;

  assign first_img = (mol_cnt_q == '0) && (img_cnt_q == '0);

  always_comb begin
    cfg_ext = CMP_W'(count_q);
    if (cfg_ext == '0) begin
      count_m1 = '0;
    end else if (cfg_ext > MaxCount) begin
      count_m1 = MaxCount - CMP_W'(1);
    end else begin
      count_m1 = cfg_ext - CMP_W'(1);
    end
  end

  assign mol_ext  = CMP_W'(mol_cnt_q);
  assign run_last = (mol_ext >= count_m1);

  assign ref_eff = first_img ? in_q : ref_q;
  assign dx = DIFF_W'(in_q.x) - DIFF_W'(ref_eff.x);
  assign dy = DIFF_W'(in_q.y) - DIFF_W'(ref_eff.y);
  assign dz = DIFF_W'(in_q.z) - DIFF_W'(ref_eff.z);
  assign sx = dx * dx;
  assign sy = dy * dy;
  assign sz = dz * dz;
  assign sq_sum = DIST_W'(sx[SQ_W-2:0]) + DIST_W'(sy[SQ_W-2:0]) + DIST_W'(sz[SQ_W-2:0]);

  assign take = (img_cnt_q == '0) || (sq_sum < best_q);

  always_comb begin
    best_d     = take ? sq_sum : best_q;
    best_img_d = take ? img_cnt_q : best_img_q;
    chosen_d   = take ? in_q : chosen_q;
    ref_d      = ref_eff;
    if (has_result && (mol_cnt_q != '0)) begin
      ref_d.x = midpoint(ref_eff.x, chosen_d.x);
      ref_d.y = midpoint(ref_eff.y, chosen_d.y);
      ref_d.z = midpoint(ref_eff.z, chosen_d.z);
    end
  end

  assign idx_full  = {mol_cnt_q, best_img_d};
  assign idx_wide  = {{IDX_W{1'b0}}, idx_full};
  assign out_idx_d = (mol_cnt_q == '0) ? '0 : idx_wide[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CFG_W'(1);
      in_valid_q  <= 1'b0;
      ref_q       <= '0;
      chosen_q    <= '0;
      best_q      <= '0;
      best_img_q  <= '0;
      img_cnt_q   <= '0;
      mol_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (proc) begin
        ref_q      <= ref_d;
        chosen_q   <= chosen_d;
        best_q     <= best_d;
        best_img_q <= best_img_d;
        img_cnt_q  <= img_cnt_q + IMG_W'(1);
        if (has_result) begin
          mol_cnt_q <= run_last ? '0 : mol_cnt_q + CNT_W'(1);
        end
      end
      if (proc && has_result) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= point_t'(s_axis_tdata);
    end
    if (proc && has_result) begin
      out_idx_q  <= out_idx_d;
      out_last_q <= run_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_idx_q);
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && has_result |=> m_axis_tvalid)
    else $error("result beat not loaded after last image");

  a_img_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> img_cnt_q == $past(img_cnt_q) + IMG_W'(1))
    else $error("image counter did not advance");

  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && has_result && (mol_cnt_q == '0) |=> m_axis_tdata == '0)
    else $error("first molecule must select image zero");

  a_held_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !proc |=> in_valid_q && $stable(in_q))
    else $error("held image beat was lost");
`endif

endmodule

@@ sim/nics_result_checker.sv @@
`timescale 1ns / 100ps

module nics_result_checker
  import nics_pkg::*;
#(
  parameter int MAX_MOLECULES = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  img_valid_i,
  input  logic                  img_ready_i,
  input  logic [IN_DATA_W-1:0]  img_data_i,
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  logic [OUT_DATA_W-1:0] res_data_i,
  input  logic                  res_last_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             run_end;
  } selection_t;

  selection_t selection_q[$];

  logic [CFG_W-1:0]  run_length;
  point_t            anchor;
  point_t            pick;
  logic [DIST_W-1:0] best_dist;
  logic [IMG_W-1:0]  best_slot;
  logic [IMG_W-1:0]  slot_cnt;
  logic [11:0]       mol_cnt;
  int                report_cnt;

  function automatic logic [DIST_W-1:0] sq_dist(input point_t a, input point_t b);
    longint dx;
    longint dy;
    longint dz;
    dx = longint'(a.x) - longint'(b.x);
    dy = longint'(a.y) - longint'(b.y);
    dz = longint'(a.z) - longint'(b.z);
    return DIST_W'(dx * dx + dy * dy + dz * dz);
  endfunction

  // Floor of the mean: the 25-bit sum shifted arithmetically always fits 24 bits.
  function automatic coord_t halfway(input coord_t a, input coord_t b);
    logic signed [COORD_W:0] total;
    total = a + b;
    return coord_t'(total >>> 1);
  endfunction

  task automatic predict_image(input point_t p);
    logic [DIST_W-1:0] d;
    int                limit;
    selection_t        sel;
    if (mol_cnt == 0 && slot_cnt == 0) begin
      anchor = p;
    end
    d = sq_dist(p, anchor);
    if (slot_cnt == 0 || d < best_dist) begin
      best_dist = d;
      best_slot = slot_cnt;
      pick      = p;
    end
    if (slot_cnt != LastImage) begin
      slot_cnt = slot_cnt + 1'b1;
    end else begin
      limit = int'(run_length);
      if (limit == 0) limit = 1;
      if (limit > MAX_MOLECULES) limit = MAX_MOLECULES;
      sel.run_end = (int'(mol_cnt) >= limit - 1);
      if (mol_cnt == 0) begin
        sel.index = '0;
      end else begin
        // Eight images per molecule, so the index is just the two counters side by side.
        sel.index = {mol_cnt, best_slot};
        anchor.x  = halfway(anchor.x, pick.x);
        anchor.y  = halfway(anchor.y, pick.y);
        anchor.z  = halfway(anchor.z, pick.z);
      end
      selection_q.push_back(sel);
      slot_cnt = '0;
      mol_cnt  = sel.run_end ? '0 : mol_cnt + 1'b1;
    end
  endtask

  task automatic check_result();
    selection_t want;
    selection_t got;
    got.index   = res_data_i[IDX_W-1:0];
    got.run_end = res_last_i;
    if (selection_q.size() == 0) begin
      fail_count_o++;
      if (report_cnt < 10) begin
        $display("%0t: unexpected result beat: index %0d last %b", $time, got.index,
                 got.run_end);
      end
      report_cnt++;
    end else begin
      want = selection_q.pop_front();
      if (got !== want) begin
        fail_count_o++;
        if (report_cnt < 10) begin
          $display("%0t: result mismatch: expected index %0d last %b, got index %0d last %b",
                   $time, want.index, want.run_end, got.index, got.run_end);
        end
        report_cnt++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      selection_q.delete();
      run_length   = CFG_W'(1);
      anchor       = '0;
      pick         = '0;
      best_dist    = '0;
      best_slot    = '0;
      slot_cnt     = '0;
      mol_cnt      = '0;
      report_cnt   = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) run_length = cfg_wdata_i;
      if (img_valid_i && img_ready_i) predict_image(point_t'(img_data_i));
      if (res_valid_i && res_ready_i) check_result();
      pending_o = selection_q.size();
    end
  end

endmodule

@@ sim/tb_nearest_image_chain_select_unit.sv @@
`timescale 1ns / 100ps

module tb_nearest_image_chain_select_unit;
  import nics_pkg::*;

  localparam int MaxMolecules = 4096;
  localparam int ItemTarget   = 1950;
  localparam int QuietTail    = 250;

  localparam coord_t CoordMin = coord_t'(24'h800000);
  localparam coord_t CoordMax = coord_t'(24'h7FFFFF);

  typedef enum logic [1:0] {
    StyleSpread,
    StyleCluster,
    StyleTies,
    StyleExtremes
  } img_style_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  int fail_count;
  int pending;
  int items_sent = 0;
  bit quiet      = 1'b0;
  int stall_left = 0;

  nearest_image_chain_select_unit #(
    .MAX_MOLECULES(MaxMolecules)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  nics_result_checker #(
    .MAX_MOLECULES(MaxMolecules)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .img_valid_i (s_axis_tvalid),
    .img_ready_i (s_axis_tready),
    .img_data_i  (s_axis_tdata),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_i  (m_axis_tdata),
    .res_last_i  (m_axis_tlast),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("[nearest_image_chain_select_unit] ERROR");
    $finish;
  end

  // Receiver side: tready is dropped in random stall bursts.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 3))
      0:       return CoordMin;
      1:       return CoordMax;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Called and returning at a falling edge; the valid stays high between beats unless a random gap comes first.
  task automatic send_image(input coord_t x, input coord_t y, input coord_t z);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
    if (items_sent >= ItemTarget - QuietTail) quiet = 1'b1;
  endtask

  task automatic write_run_length(input logic [CFG_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    // Beats of an unfinished molecule may still sit in the pipeline.
    repeat (6) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_images(input img_style_e style, input int count);
    point_t base;
    point_t twin;
    point_t p;
    base = {rand_coord(), rand_coord(), rand_coord()};
    twin = {rand_coord(), rand_coord(), rand_coord()};
    for (int i = 0; i < count; i++) begin
      case (style)
        StyleCluster: begin
          p.x = base.x + coord_t'(int'($urandom_range(0, 64)) - 32);
          p.y = base.y + coord_t'(int'($urandom_range(0, 64)) - 32);
          p.z = base.z + coord_t'(int'($urandom_range(0, 64)) - 32);
        end
        StyleTies:     p = $urandom_range(0, 1) ? base : twin;
        StyleExtremes: p = {pick_extreme(), pick_extreme(), pick_extreme()};
        default:       p = {rand_coord(), rand_coord(), rand_coord()};
      endcase
      send_image(p.x, p.y, p.z);
    end
  endtask

  function automatic img_style_e rand_style();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return StyleCluster;
    if (r < 13) return StyleSpread;
    if (r < 17) return StyleTies;
    return StyleExtremes;
  endfunction

  function automatic logic [CFG_W-1:0] rand_run_length();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return CFG_W'(MaxMolecules);
      3:       return CFG_W'($urandom_range(MaxMolecules + 1, 8190));
      4:       return CFG_W'($urandom_range(7, 40));
      default: return CFG_W'($urandom_range(1, 6));
    endcase
  endfunction

  initial begin
    int molecules;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // A run of one molecule with the reset run length: the answer is always image 0.
    send_image(CoordMax, CoordMax, CoordMax);
    send_image(CoordMin, CoordMin, CoordMin);
    send_image('0, '0, '0);
    send_image('1, '1, '1);
    send_images(StyleSpread, 4);

    // Two molecules: the farthest corner, an exact hit, then a tie that must lose.
    write_run_length(CFG_W'(2));
    send_image(CoordMin, CoordMin, CoordMin);
    send_images(StyleExtremes, 7);
    send_image(CoordMax, CoordMax, CoordMax);
    send_image(CoordMin, CoordMin, CoordMin);
    send_image(CoordMin, CoordMin, CoordMin);
    send_image(CoordMin, CoordMax, CoordMin);
    send_image(CoordMax, CoordMin, CoordMax);
    send_images(StyleSpread, 3);

    while (items_sent < ItemTarget) begin
      write_run_length(rand_run_length());
      molecules = $urandom_range(1, 10);
      for (int m = 0; m < molecules; m++) send_images(rand_style(), 8);
      // A partial molecule leaves the block mid-molecule for the next setting.
      if ($urandom_range(0, 3) == 0) send_images(rand_style(), $urandom_range(1, 7));
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[nearest_image_chain_select_unit] OK");
    end else begin
      $display("[nearest_image_chain_select_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/nics_pkg.sv
rtl/nearest_image_chain_select_unit.sv
sim/nics_result_checker.sv
sim/tb_nearest_image_chain_select_unit.sv
